/* rtl/ngg_pkg.sv */
// Shared types and constants for the noise gate gain computer.
package ngg_pkg;

  localparam int unsigned LEVEL_W         = 17;
  localparam int unsigned DIFF_W          = LEVEL_W + 1;
  localparam int unsigned HYST_W          = 16;
  localparam int unsigned RANGE_W         = 16;
  localparam int unsigned SLOPE_W         = 20;
  localparam int unsigned SLOPE_FRAC      = 15;
  localparam int unsigned HOLD_COUNT_BITS = 20;
  localparam int unsigned PADDR_W         = 5;
  localparam int unsigned PDATA_W         = 32;

  localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET = -17'sd15360;
  localparam logic [RANGE_W-1:0]        RANGE_RESET     = 16'd20480;

  typedef enum logic [1:0] {
    GATE_CLOSED = 2'd0,
    GATE_OPEN   = 2'd1,
    GATE_HOLD   = 2'd2
  } gate_mode_e;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_HYSTERESIS = 3'd2,
    REG_RANGE      = 3'd3,
    REG_SLOPE      = 3'd4,
    REG_HOLD_COUNT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                        enable;
    logic signed [LEVEL_W-1:0]   threshold_db;
    logic [HYST_W-1:0]           hysteresis_db;
    logic [RANGE_W-1:0]          atten_range;
    logic [SLOPE_W-1:0]          slope;
    logic [HOLD_COUNT_BITS-1:0]  hold_count;
  } cfg_t;

endpackage

/* rtl/noise_gate_gain_computer_unit.sv */
// Noise gate gain computer top level: input stage, gate state machine and result register.
//
// One level per transfer, one result per level, sustained at one item per clock:
// an input register holds the level's hysteresis comparison and its excess over the
// threshold, and the gate state update together with the 18x21-bit slope multiply,
// rounding and clamp run from that register into the result register. While the
// output is held off, the two registers fill and the input stalls until the result
// is taken. The gate state (closed, open, hold and the hold counter) is updated as
// an item moves into the result register, so each item sees the state left by the
// one before it. Configuration registers are written through the APB port; the user
// must write them only while no item is in flight, as the block does not enforce it.
module noise_gate_gain_computer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ngg_pkg::LEVEL_W-1:0]  level_db_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ngg_pkg::LEVEL_W-1:0]  gain_db_o,
  output logic [1:0]                          gate_status_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ngg_pkg::PADDR_W-1:0]         paddr,
  input  logic [ngg_pkg::PDATA_W-1:0]         pwdata,
  output logic [ngg_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  ngg_pkg::cfg_t cfg;

  ngg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input stage.
  logic                                valid_a_q;
  logic signed [ngg_pkg::DIFF_W-1:0]   diff_a_q;
  logic                                below_leave_a_q;
  logic signed [ngg_pkg::DIFF_W-1:0]   diff_d;
  logic signed [ngg_pkg::DIFF_W-1:0]   leave_lvl;
  logic                                below_leave_d;
  logic                                at_thr_a;
  logic                                adv_b;

  assign diff_d        = {level_db_i[ngg_pkg::LEVEL_W-1], level_db_i}
                       - {cfg.threshold_db[ngg_pkg::LEVEL_W-1], cfg.threshold_db};
  assign leave_lvl     = {cfg.threshold_db[ngg_pkg::LEVEL_W-1], cfg.threshold_db}
                       - $signed({2'b00, cfg.hysteresis_db});
  assign below_leave_d = $signed({level_db_i[ngg_pkg::LEVEL_W-1], level_db_i}) < leave_lvl;
  assign at_thr_a      = !diff_a_q[ngg_pkg::DIFF_W-1];

  assign adv_b      = !out_valid_o || out_ready_i;
  assign in_ready_o = !valid_a_q || adv_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      diff_a_q        <= diff_d;
      below_leave_a_q <= below_leave_d;
    end
  end

  // Gate state.
  ngg_pkg::gate_mode_e                  mode_q, mode_d;
  logic [ngg_pkg::HOLD_COUNT_BITS-1:0]  hold_q, hold_d;
  logic                                 step_b;

  assign step_b = valid_a_q && adv_b;

  always_comb begin
    mode_d = mode_q;
    hold_d = hold_q;
    if (cfg.enable) begin
      case (mode_q)
        ngg_pkg::GATE_OPEN: begin
          if (below_leave_a_q) begin
            mode_d = ngg_pkg::GATE_HOLD;
            hold_d = cfg.hold_count;
          end
        end
        ngg_pkg::GATE_HOLD: begin
          if (at_thr_a) begin
            mode_d = ngg_pkg::GATE_OPEN;
          end else if (hold_q == '0) begin
            mode_d = ngg_pkg::GATE_CLOSED;
          end else begin
            hold_d = hold_q - 1'b1;
          end
        end
        default: begin
          mode_d = at_thr_a ? ngg_pkg::GATE_OPEN : ngg_pkg::GATE_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ngg_pkg::GATE_CLOSED;
      hold_q <= '0;
    end else if (step_b) begin
      mode_q <= mode_d;
      hold_q <= hold_d;
    end
  end

  // Result computation.
  logic signed [ngg_pkg::LEVEL_W-1:0] closed_gain;
  logic signed [ngg_pkg::LEVEL_W-1:0] gain_d;
  logic [1:0]                         status_d;

  ngg_gain u_gain (
    .diff_i  (diff_a_q),
    .slope_i (cfg.slope),
    .range_i (cfg.atten_range),
    .gain_o  (closed_gain)
  );

  always_comb begin
    status_d = mode_d;
    if (cfg.enable && mode_d == ngg_pkg::GATE_CLOSED) begin
      gain_d = closed_gain;
    end else begin
      gain_d = '0;
    end
  end

  logic                               out_valid_q;
  logic signed [ngg_pkg::LEVEL_W-1:0] gain_q;
  logic [1:0]                         status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_b) begin
      out_valid_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_b) begin
      gain_q   <= gain_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gain_db_o     = gain_q;
  assign gate_status_o = status_q;

  // The gain is never positive.
  a_gain_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_db_o[ngg_pkg::LEVEL_W-1] || gain_db_o == '0))
    else $error("positive gain at output");

  // Open and hold report unity gain.
  a_open_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gate_status_o != ngg_pkg::GATE_CLOSED) |-> gain_db_o == '0)
    else $error("nonzero gain while gate is open or holding");

  // A step taken while disabled leaves the gate state untouched.
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_b && !cfg.enable) |=> ($stable(mode_q) && $stable(hold_q)))
    else $error("gate state changed while disabled");

  // The hold counter only moves when the gate is in or enters hold.
  a_hold_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hold_q) |-> mode_q == ngg_pkg::GATE_HOLD)
    else $error("hold counter changed outside hold");

endmodule

/* rtl/ngg_cfg_regs.sv */
// APB-style configuration register file for the noise gate gain computer.
module ngg_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ngg_pkg::PADDR_W-1:0]    paddr,
  input  logic [ngg_pkg::PDATA_W-1:0]    pwdata,
  output logic [ngg_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready,
  output ngg_pkg::cfg_t                  cfg_o
);

  ngg_pkg::cfg_t     cfg_q;
  ngg_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = ngg_pkg::reg_idx_e'(paddr[ngg_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.threshold_db  <= ngg_pkg::THRESHOLD_RESET;
      cfg_q.hysteresis_db <= '0;
      cfg_q.atten_range   <= ngg_pkg::RANGE_RESET;
      cfg_q.slope         <= '0;
      cfg_q.hold_count    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ngg_pkg::REG_ENABLE:     cfg_q.enable        <= pwdata[0];
        ngg_pkg::REG_THRESHOLD:  cfg_q.threshold_db  <= $signed(pwdata[ngg_pkg::LEVEL_W-1:0]);
        ngg_pkg::REG_HYSTERESIS: cfg_q.hysteresis_db <= pwdata[ngg_pkg::HYST_W-1:0];
        ngg_pkg::REG_RANGE:      cfg_q.atten_range   <= pwdata[ngg_pkg::RANGE_W-1:0];
        ngg_pkg::REG_SLOPE:      cfg_q.slope         <= pwdata[ngg_pkg::SLOPE_W-1:0];
        ngg_pkg::REG_HOLD_COUNT: cfg_q.hold_count    <= pwdata[ngg_pkg::HOLD_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ngg_pkg::REG_ENABLE:     prdata = {31'd0, cfg_q.enable};
      ngg_pkg::REG_THRESHOLD:  prdata = 32'(cfg_q.threshold_db);
      ngg_pkg::REG_HYSTERESIS: prdata = 32'(cfg_q.hysteresis_db);
      ngg_pkg::REG_RANGE:      prdata = 32'(cfg_q.atten_range);
      ngg_pkg::REG_SLOPE:      prdata = 32'(cfg_q.slope);
      ngg_pkg::REG_HOLD_COUNT: prdata = 32'(cfg_q.hold_count);
      default:                 prdata = '0;
    endcase
  end

endmodule

/* rtl/ngg_gain.sv */
// Closed-gate gain: scales the level excess by the slope, rounds and clamps.
module ngg_gain (
  input  logic signed [ngg_pkg::DIFF_W-1:0]  diff_i,
  input  logic [ngg_pkg::SLOPE_W-1:0]        slope_i,
  input  logic [ngg_pkg::RANGE_W-1:0]        range_i,
  output logic signed [ngg_pkg::LEVEL_W-1:0] gain_o
);

  localparam int unsigned PROD_W = ngg_pkg::DIFF_W + ngg_pkg::SLOPE_W + 1;
  localparam int unsigned RND_W  = PROD_W + 1;
  localparam int unsigned Q_W    = RND_W - ngg_pkg::SLOPE_FRAC;

  logic signed [ngg_pkg::SLOPE_W:0]  slope_s;
  logic signed [PROD_W-1:0]          prod;
  logic signed [RND_W-1:0]           rnd;
  logic signed [Q_W-1:0]             quo;
  logic signed [Q_W-1:0]             neg_range;

  assign slope_s   = $signed({1'b0, slope_i});
  assign prod      = diff_i * slope_s;
  // Adding one half before the arithmetic shift rounds halves toward plus infinity.
  assign rnd       = {prod[PROD_W-1], prod} + (RND_W'(1) <<< (ngg_pkg::SLOPE_FRAC - 1));
  assign quo       = rnd[RND_W-1:ngg_pkg::SLOPE_FRAC];
  assign neg_range = -$signed({{(Q_W-ngg_pkg::RANGE_W){1'b0}}, range_i});

  always_comb begin
    if (quo > 0) begin
      gain_o = '0;
    end else if (quo < neg_range) begin
      gain_o = neg_range[ngg_pkg::LEVEL_W-1:0];
    end else begin
      gain_o = quo[ngg_pkg::LEVEL_W-1:0];
    end
  end

endmodule

/* tb/tb_noise_gate_gain_computer_unit.sv */
// Self-checking testbench for the noise gate gain computer: directed table, then random phases.
module tb_noise_gate_gain_computer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] IDX_UNMAPPED = 3'd7;

  typedef enum logic {ROW_LEVEL, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                          kind;
    logic [2:0]                         idx;
    logic [31:0]                        value;
    bit                                 typed;
    logic signed [ngg_pkg::LEVEL_W-1:0] gain;
    ngg_pkg::gate_mode_e                status;
  } dir_row_t;

  typedef struct {
    logic signed [ngg_pkg::LEVEL_W-1:0] gain;
    ngg_pkg::gate_mode_e                status;
  } gate_result_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic signed [ngg_pkg::LEVEL_W-1:0]  level_db_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [ngg_pkg::LEVEL_W-1:0]  gain_db_o;
  logic [1:0]                          gate_status_o;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [ngg_pkg::PADDR_W-1:0]         paddr;
  logic [ngg_pkg::PDATA_W-1:0]         pwdata;
  logic [ngg_pkg::PDATA_W-1:0]         prdata;
  logic                                pready;

  noise_gate_gain_computer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .level_db_i    (level_db_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .gain_db_o     (gain_db_o),
    .gate_status_o (gate_status_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow copy of the configuration and of the gate state.
  logic                                 en_sh;
  logic signed [ngg_pkg::LEVEL_W-1:0]   thr_sh;
  logic [ngg_pkg::HYST_W-1:0]           hyst_sh;
  logic [ngg_pkg::RANGE_W-1:0]          range_sh;
  logic [ngg_pkg::SLOPE_W-1:0]          slope_sh;
  logic [ngg_pkg::HOLD_COUNT_BITS-1:0]  hold_sh;
  ngg_pkg::gate_mode_e                  gate_now;
  logic [ngg_pkg::HOLD_COUNT_BITS-1:0]  hold_rem_sh;

  gate_result_t gain_expect_q[$];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int          rx_hold_off;
  int          seg_left;
  int          seg_kind;
  int          err_cnt;
  int          levels_sent;
  int          directed_levels;
  int          reg_writes;
  int          gains_checked;
  int          open_seen;
  int          hold_seen;

  dir_row_t dir_tbl[$] = '{
    '{ROW_LEVEL, '0, 32'h0000_FFFF, 1'b1, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'hFFFF_0000, 1'b1, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, IDX_UNMAPPED, 32'h0000_0001, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'h0000_0000, 1'b1, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_ENABLE, 32'h0000_0001, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'hFFFF_0000, 1'b1, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_THRESHOLD, 32'h0000_0000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_SLOPE, 32'h0000_8000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_HYSTERESIS, 32'h0000_0100, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_HOLD_COUNT, 32'h0000_0002, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'hFFFF_0000, 1'b1, -17'sd20480, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd100, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'h0000_0000, 1'b1, 17'sd0, ngg_pkg::GATE_OPEN},
    '{ROW_LEVEL, '0, -32'sd256, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd257, 1'b1, 17'sd0, ngg_pkg::GATE_HOLD},
    '{ROW_LEVEL, '0, -32'sd300, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'sd5, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'hFFFF_0000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd1, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd1, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd1, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_ENABLE, 32'h0000_0000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'h0000_FFFF, 1'b1, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_ENABLE, 32'h0000_0001, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_SLOPE, 32'h0000_4000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd1, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, -32'sd3, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_THRESHOLD, 32'h0000_FFFF, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_SLOPE, 32'h000F_FFFF, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_RANGE, 32'h0000_FFFF, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'hFFFF_0000, 1'b1, -17'sd65535, ngg_pkg::GATE_CLOSED},
    '{ROW_REG, ngg_pkg::REG_THRESHOLD, 32'hFFFF_0000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'h0000_FFFF, 1'b1, 17'sd0, ngg_pkg::GATE_OPEN},
    '{ROW_REG, ngg_pkg::REG_HOLD_COUNT, 32'h0000_0000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED},
    '{ROW_LEVEL, '0, 32'hFFFF_0000, 1'b0, 17'sd0, ngg_pkg::GATE_CLOSED}
  };

  // Advances the shadow gate by one level and returns the gain and status it yields.
  function automatic void gate_step(input logic signed [ngg_pkg::LEVEL_W-1:0] lvl,
                                    output logic signed [ngg_pkg::LEVEL_W-1:0] gain,
                                    output ngg_pkg::gate_mode_e st);
    int     lvl_i;
    int     thr_i;
    longint prod;
    longint g;
    lvl_i = int'(lvl);
    thr_i = int'(thr_sh);
    gain = '0;
    if (!en_sh) begin
      st = gate_now;
      return;
    end
    case (gate_now)
      ngg_pkg::GATE_OPEN: begin
        if (lvl_i < thr_i - int'(hyst_sh)) begin
          gate_now = ngg_pkg::GATE_HOLD;
          hold_rem_sh = hold_sh;
        end
      end
      ngg_pkg::GATE_HOLD: begin
        if (lvl_i >= thr_i) gate_now = ngg_pkg::GATE_OPEN;
        else if (hold_rem_sh == '0) gate_now = ngg_pkg::GATE_CLOSED;
        else hold_rem_sh = hold_rem_sh - 1'b1;
      end
      default: begin
        gate_now = (lvl_i >= thr_i) ? ngg_pkg::GATE_OPEN : ngg_pkg::GATE_CLOSED;
      end
    endcase
    if (gate_now == ngg_pkg::GATE_CLOSED) begin
      prod = longint'(lvl_i - thr_i) * longint'(slope_sh);
      // Arithmetic shift gives the floor, so halves round toward plus infinity.
      g = (prod + (longint'(1) << (ngg_pkg::SLOPE_FRAC - 1))) >>> ngg_pkg::SLOPE_FRAC;
      if (g > 0) g = 0;
      if (g < -longint'(range_sh)) g = -longint'(range_sh);
      gain = g[ngg_pkg::LEVEL_W-1:0];
    end
    st = gate_now;
  endfunction

  // Levels come in runs above, inside and below the hysteresis band so that
  // the gate walks through open, hold and hold expiry; the rest is noise.
  function automatic logic signed [ngg_pkg::LEVEL_W-1:0] next_level();
    int          v;
    int          thr;
    int          hy;
    logic [31:0] bits;
    thr = int'(thr_sh);
    hy = int'(hyst_sh);
    if (seg_left == 0) begin
      seg_kind = $urandom_range(0, 5);
      seg_left = $urandom_range(1, (hold_sh < 20) ? int'(hold_sh) + 4 : 24);
    end
    seg_left--;
    case (seg_kind)
      0, 1: v = thr + int'($urandom_range(0, 600));
      2: v = thr - int'($urandom_range(0, hy));
      3, 4: v = thr - hy - 1 - int'($urandom_range(0, 3000));
      default: begin
        bits = $urandom();
        if ($urandom_range(0, 3) == 0) v = bits[31] ? -65536 : 65535;
        else v = int'($signed(bits[ngg_pkg::LEVEL_W-1:0]));
      end
    endcase
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[ngg_pkg::LEVEL_W-1:0];
  endfunction

  task automatic send_level(input logic signed [ngg_pkg::LEVEL_W-1:0] lvl, input bit typed,
                            input logic signed [ngg_pkg::LEVEL_W-1:0] t_gain,
                            input ngg_pkg::gate_mode_e t_st);
    gate_result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_db_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    gate_step(lvl, r.gain, r.status);
    if (typed) begin
      r.gain = t_gain;
      r.status = t_st;
    end
    gain_expect_q.push_back(r);
    levels_sent++;
  endtask

  // Register writes wait until every result in flight has been delivered.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    in_valid_i <= 1'b0;
    while (gain_expect_q.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ngg_pkg::REG_ENABLE:     en_sh = val[0];
      ngg_pkg::REG_THRESHOLD:  thr_sh = val[ngg_pkg::LEVEL_W-1:0];
      ngg_pkg::REG_HYSTERESIS: hyst_sh = val[ngg_pkg::HYST_W-1:0];
      ngg_pkg::REG_RANGE:      range_sh = val[ngg_pkg::RANGE_W-1:0];
      ngg_pkg::REG_SLOPE:      slope_sh = val[ngg_pkg::SLOPE_W-1:0];
      ngg_pkg::REG_HOLD_COUNT: hold_sh = val[ngg_pkg::HOLD_COUNT_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic cfg_random();
    logic [31:0] thr;
    thr = ($urandom_range(0, 3) == 0) ? $urandom() : 32'(int'($urandom_range(0, 25000)) - 20000);
    cfg_write(ngg_pkg::REG_THRESHOLD, thr);
    cfg_write(ngg_pkg::REG_HYSTERESIS, $urandom_range(0, 2048));
    cfg_write(ngg_pkg::REG_RANGE, $urandom_range(0, 16'hFFFF));
    cfg_write(ngg_pkg::REG_SLOPE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                              : $urandom_range(0, 32'h2_0000));
    cfg_write(ngg_pkg::REG_HOLD_COUNT, $urandom_range(0, 12));
    cfg_write(ngg_pkg::REG_ENABLE, 32'd1);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    level_db_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    en_sh = 1'b0;
    thr_sh = ngg_pkg::THRESHOLD_RESET;
    hyst_sh = '0;
    range_sh = ngg_pkg::RANGE_RESET;
    slope_sh = '0;
    hold_sh = '0;
    gate_now = ngg_pkg::GATE_CLOSED;
    hold_rem_sh = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_off = 0;
    seg_left = 0;
    seg_kind = 0;
    err_cnt = 0;
    levels_sent = 0;
    directed_levels = 0;
    reg_writes = 0;
    gains_checked = 0;
    open_seen = 0;
    hold_seen = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_REG) begin
        cfg_write(dir_tbl[i].idx, dir_tbl[i].value);
      end else begin
        send_level(dir_tbl[i].value[ngg_pkg::LEVEL_W-1:0], dir_tbl[i].typed,
                   dir_tbl[i].gain, dir_tbl[i].status);
        directed_levels++;
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        3: begin tx_idle_pct = 18; rx_stall_pct = 18; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      case (ph)
        1: begin
          cfg_write(ngg_pkg::REG_THRESHOLD, 32'hFFFF_0000);
          cfg_write(ngg_pkg::REG_HYSTERESIS, 32'h0000_FFFF);
          cfg_write(ngg_pkg::REG_RANGE, 32'h0000_FFFF);
          cfg_write(ngg_pkg::REG_SLOPE, 32'h000F_FFFF);
          cfg_write(ngg_pkg::REG_HOLD_COUNT, 32'h000F_FFFF);
        end
        2: begin
          cfg_write(ngg_pkg::REG_THRESHOLD, 32'h0000_FFFF);
          cfg_write(ngg_pkg::REG_HYSTERESIS, 32'd0);
          cfg_write(ngg_pkg::REG_RANGE, 32'd0);
          cfg_write(ngg_pkg::REG_SLOPE, 32'd0);
          cfg_write(ngg_pkg::REG_HOLD_COUNT, 32'd0);
        end
        default: cfg_random();
      endcase
      if (ph == 5) begin
        // A bypassed stretch in the middle of live traffic.
        for (int i = 0; i < 40; i++) send_level(next_level(), 1'b0, '0, ngg_pkg::GATE_CLOSED);
        cfg_write(ngg_pkg::REG_ENABLE, 32'd0);
        for (int i = 0; i < 25; i++) send_level(next_level(), 1'b0, '0, ngg_pkg::GATE_CLOSED);
        cfg_write(ngg_pkg::REG_ENABLE, 32'd1);
        for (int i = 0; i < 60; i++) send_level(next_level(), 1'b0, '0, ngg_pkg::GATE_CLOSED);
      end else begin
        // The pressure phase holds the output off long enough to back up the input.
        if (ph == 4) rx_hold_off = 80;
        for (int i = 0; i < 125; i++) send_level(next_level(), 1'b0, '0, ngg_pkg::GATE_CLOSED);
      end
    end

    in_valid_i <= 1'b0;
    for (int w = 0; w < 5000 && gain_expect_q.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (gain_expect_q.size() != 0) begin
      $display("%0d expected gains never arrived", gain_expect_q.size());
      err_cnt += gain_expect_q.size();
    end
    $display("Sent %0d levels (%0d from the directed table) across %0d register writes.",
             levels_sent, directed_levels, reg_writes);
    $display("Checked %0d gains; gate reported open %0d times and hold %0d times; %0d errors.",
             gains_checked, open_seen, hold_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_side
    gate_result_t want;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (gain_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result gain=%0d status=%0d", $realtime, gain_db_o,
                     gate_status_o);
        end else begin
          want = gain_expect_q.pop_front();
          gains_checked++;
          if (want.status == ngg_pkg::GATE_OPEN) open_seen++;
          if (want.status == ngg_pkg::GATE_HOLD) hold_seen++;
          if (gain_db_o !== want.gain || gate_status_o !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch gain exp %0d got %0d, status exp %0d got %0d", $realtime,
                       want.gain, gain_db_o, want.status, gate_status_o);
          end
        end
      end
      if (rx_hold_off > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_off--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d gains outstanding", gain_expect_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
